// ----- design/io_latency_stats_monitor_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the I/O latency statistics monitor
// Shared wrappers for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef IO_LATENCY_STATS_MONITOR_MACROS_SVH
`define IO_LATENCY_STATS_MONITOR_MACROS_SVH

// property checked on every rising edge while out of reset
`define ILSM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// implication checked in the next cycle
`define ILSM_ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// ----- design/ilsm_pkg.sv -----
// ----------------------------------------------------------------------------
// ilsm_pkg
// Shared constants, result codes and quantile table of the latency monitor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package ilsm_pkg;
	localparam int WIN_DEPTH = 1024;
	localparam int WIN_AW    = $clog2(WIN_DEPTH);
	localparam int WIN_LW    = $clog2(WIN_DEPTH + 1);

	localparam int IDX_W     = 5;
	localparam int QTL_W     = 17;
	localparam int PROD_W    = QTL_W + WIN_LW;
	localparam int RANK_DEN  = 100000;

	localparam logic [1:0] REQ_ISSUE  = 2'd0;
	localparam logic [1:0] REQ_DONE   = 2'd1;
	localparam logic [1:0] REQ_REPORT = 2'd2;

	localparam logic [IDX_W-1:0] RES_RD_CNT   = 5'd0;
	localparam logic [IDX_W-1:0] RES_WR_CNT   = 5'd1;
	localparam logic [IDX_W-1:0] RES_RD_SUM   = 5'd2;
	localparam logic [IDX_W-1:0] RES_WR_SUM   = 5'd3;
	localparam logic [IDX_W-1:0] RES_RD_MEAN  = 5'd4;
	localparam logic [IDX_W-1:0] RES_WR_MEAN  = 5'd5;
	localparam logic [IDX_W-1:0] RES_ALL_MEAN = 5'd6;
	localparam logic [IDX_W-1:0] RES_MIN      = 5'd7;
	localparam logic [IDX_W-1:0] RES_MAX      = 5'd8;
	localparam logic [IDX_W-1:0] RES_DEPTH    = 5'd9;
	localparam logic [IDX_W-1:0] RES_LEN      = 5'd10;
	localparam logic [IDX_W-1:0] RES_QTL_0    = 5'd11;
	localparam logic [IDX_W-1:0] RES_LAST     = 5'd21;

	function automatic logic [QTL_W-1:0] qtl_point(input logic [3:0] i);
		logic [QTL_W-1:0] p;
		case (i)
			4'd0:    p = 17'd10000;
			4'd1:    p = 17'd20000;
			4'd2:    p = 17'd30000;
			4'd3:    p = 17'd40000;
			4'd4:    p = 17'd50000;
			4'd5:    p = 17'd60000;
			4'd6:    p = 17'd70000;
			4'd7:    p = 17'd80000;
			4'd8:    p = 17'd90000;
			4'd9:    p = 17'd99000;
			default: p = 17'd99999;
		endcase
		return p;
	endfunction
endpackage
`default_nettype wire

// ----- design/io_latency_stats_monitor.sv -----
// ----------------------------------------------------------------------------
// io_latency_stats_monitor
// Tracks I/O counts, service-time sums, extremes, queue depth and a sliding
// window of the latest service times; streams a 22-beat report on request.
// ----------------------------------------------------------------------------
// Issue and completion beats are taken one per cycle. A report holds off the
// input until its last beat is taken. Counters, sums and extremes are
// prepared, then sent; each mean is computed in the shared radix-2 divider,
// and each quantile by a 32-step bitwise value search that scans the window
// memory through its single read port once per step. The rank test is done as
// count * 100000 <= p * len, so no division by the rank scale is needed. A
// quantile of an empty window skips the search. No reset pass is needed; only
// filled window entries are ever read.
`timescale 1ns / 1ps
`default_nettype none
module io_latency_stats_monitor (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // resp_time_ns[31:0]
	input  wire logic [2:0]  s_tuser,   // req_type[1:0], is_write[2]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata,   // result_value[63:0]
	output logic [4:0]       m_tuser,   // result_index[4:0]
	output logic             m_tlast
);
	localparam int AW = ilsm_pkg::WIN_AW;
	localparam int LW = ilsm_pkg::WIN_LW;

	typedef enum logic [2:0] {ST_IDLE, ST_PREP, ST_DIV, ST_SCAN, ST_SEND} state_t;

	state_t st_q;

	logic [47:0] rd_cnt_q, wr_cnt_q;
	logic [63:0] rd_sum_q, wr_sum_q;
	logic [31:0] min_q, max_q;
	logic [15:0] outst_q;
	logic [AW-1:0] wp_q;
	logic [LW-1:0] fill_q;

	logic [31:0] mem [ilsm_pkg::WIN_DEPTH];
	logic [31:0] rdata_s1;
	logic        rv_s1;

	logic [4:0]  idx_q;
	logic [63:0] val_q;
	logic [ilsm_pkg::PROD_W-1:0] prod_q;
	logic [63:0] dnum_q;
	logic [48:0] dden_q;
	logic [49:0] drem_q;
	logic [5:0]  dcnt_q;
	logic [LW-1:0] ra_q, cnt_q;
	logic [31:0] ans_q;
	logic [4:0]  bit_q;

	logic        in_beat, done_beat, rd_en;
	logic [1:0]  req_type;
	logic [31:0] t_in, trial, ans_set;
	logic [32:0] mask;
	logic [49:0] rem_sh;
	logic        q_bit;
	logic [63:0] quot;
	logic [48:0] cnt_sum;
	logic [ilsm_pkg::PROD_W-1:0] cnt_scaled;
	logic        rank_ok;

	assign req_type  = s_tuser[1:0];
	assign t_in      = s_tdata;
	assign s_tready  = (st_q == ST_IDLE);
	assign in_beat   = s_tvalid && s_tready;
	assign done_beat = in_beat && (req_type == ilsm_pkg::REQ_DONE);
	assign rd_en     = (st_q == ST_SCAN) && (ra_q < fill_q);

	assign mask    = (33'd1 << bit_q) - 33'd1;
	assign trial   = ans_q | mask[31:0];
	assign ans_set = ans_q | (32'd1 << bit_q);

	// count <= floor(p * len / 100000) holds exactly when count * 100000 <= p * len
	assign cnt_scaled = ilsm_pkg::PROD_W'(cnt_q) * ilsm_pkg::PROD_W'(ilsm_pkg::RANK_DEN);
	assign rank_ok    = (cnt_scaled <= prod_q);

	assign rem_sh  = {drem_q[48:0], dnum_q[63]};
	assign q_bit   = (rem_sh >= {1'b0, dden_q});
	assign quot    = {dnum_q[62:0], q_bit};
	assign cnt_sum = {1'b0, rd_cnt_q} + {1'b0, wr_cnt_q};

	assign m_tvalid = (st_q == ST_SEND);
	assign m_tdata  = val_q;
	assign m_tuser  = idx_q;
	assign m_tlast  = (idx_q == ilsm_pkg::RES_LAST);

	// window memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (done_beat) begin
			mem[wp_q] <= t_in;
		end
		if (rd_en) begin
			rdata_s1 <= mem[ra_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			rd_cnt_q    <= '0;
			wr_cnt_q    <= '0;
			rd_sum_q    <= '0;
			wr_sum_q    <= '0;
			min_q       <= '1;
			max_q       <= '0;
			outst_q     <= '0;
			wp_q        <= '0;
			fill_q      <= '0;
			rv_s1       <= 1'b0;
			idx_q       <= '0;
			val_q       <= '0;
			prod_q      <= '0;
			dnum_q      <= '0;
			dden_q      <= '0;
			drem_q      <= '0;
			dcnt_q      <= '0;
			ra_q        <= '0;
			cnt_q       <= '0;
			ans_q       <= '0;
			bit_q       <= '0;
		end else begin
			rv_s1 <= rd_en;
			unique case (st_q)
				ST_IDLE: begin
					if (in_beat) begin
						case (req_type)
							ilsm_pkg::REQ_ISSUE: begin
								outst_q <= outst_q + 16'd1;
							end
							ilsm_pkg::REQ_DONE: begin
								if (s_tuser[2]) begin
									wr_cnt_q <= wr_cnt_q + 48'd1;
									wr_sum_q <= wr_sum_q + 64'(t_in);
								end else begin
									rd_cnt_q <= rd_cnt_q + 48'd1;
									rd_sum_q <= rd_sum_q + 64'(t_in);
								end
								if (t_in > max_q) max_q <= t_in;
								if (t_in < min_q) min_q <= t_in;
								outst_q <= outst_q - 16'd1;
								wp_q <= (wp_q == AW'(ilsm_pkg::WIN_DEPTH - 1)) ? '0 : wp_q + 1'b1;
								if (fill_q != LW'(ilsm_pkg::WIN_DEPTH)) fill_q <= fill_q + 1'b1;
							end
							ilsm_pkg::REQ_REPORT: begin
								idx_q <= '0;
								st_q  <= ST_PREP;
							end
							default: ;
						endcase
					end
				end
				ST_PREP: begin
					st_q <= ST_SEND;
					unique case (idx_q) inside
						ilsm_pkg::RES_RD_CNT:   val_q <= 64'(rd_cnt_q);
						ilsm_pkg::RES_WR_CNT:   val_q <= 64'(wr_cnt_q);
						ilsm_pkg::RES_RD_SUM:   val_q <= rd_sum_q;
						ilsm_pkg::RES_WR_SUM:   val_q <= wr_sum_q;
						ilsm_pkg::RES_MIN:      val_q <= 64'(min_q);
						ilsm_pkg::RES_MAX:      val_q <= 64'(max_q);
						ilsm_pkg::RES_DEPTH:    val_q <= 64'(outst_q);
						ilsm_pkg::RES_LEN:      val_q <= 64'(fill_q);
						ilsm_pkg::RES_RD_MEAN, ilsm_pkg::RES_WR_MEAN,
						ilsm_pkg::RES_ALL_MEAN: begin
							drem_q      <= '0;
							dcnt_q      <= '0;
							if (idx_q == ilsm_pkg::RES_RD_MEAN) begin
								dnum_q <= rd_sum_q;
								dden_q <= 49'(rd_cnt_q);
							end else if (idx_q == ilsm_pkg::RES_WR_MEAN) begin
								dnum_q <= wr_sum_q;
								dden_q <= 49'(wr_cnt_q);
							end else begin
								dnum_q <= rd_sum_q + wr_sum_q;
								dden_q <= cnt_sum;
							end
							val_q <= '0;
							if ((idx_q == ilsm_pkg::RES_RD_MEAN && rd_cnt_q != '0) ||
							    (idx_q == ilsm_pkg::RES_WR_MEAN && wr_cnt_q != '0) ||
							    (idx_q == ilsm_pkg::RES_ALL_MEAN && cnt_sum != '0)) begin
								st_q <= ST_DIV;
							end
						end
						[ilsm_pkg::RES_QTL_0:ilsm_pkg::RES_LAST]: begin
							val_q  <= '0;
							prod_q <= ilsm_pkg::PROD_W'(ilsm_pkg::qtl_point(
								4'(idx_q - ilsm_pkg::RES_QTL_0))) * ilsm_pkg::PROD_W'(fill_q);
							ans_q  <= '0;
							bit_q  <= 5'd31;
							ra_q   <= '0;
							cnt_q  <= '0;
							if (fill_q != '0) st_q <= ST_SCAN;
						end
						default: st_q <= ST_IDLE;
					endcase
				end
				ST_DIV: begin
					dnum_q <= quot;
					drem_q <= q_bit ? rem_sh - {1'b0, dden_q} : rem_sh;
					dcnt_q <= dcnt_q + 6'd1;
					if (dcnt_q == 6'd63) begin
						val_q <= quot;
						st_q  <= ST_SEND;
					end
				end
				ST_SCAN: begin
					// count samples at or below the trial value, one per cycle
					if (rd_en) ra_q <= ra_q + 1'b1;
					if (rv_s1 && rdata_s1 <= trial) cnt_q <= cnt_q + 1'b1;
					if (ra_q == fill_q && !rv_s1) begin
						if (rank_ok) ans_q <= ans_set;
						if (bit_q == 5'd0) begin
							val_q <= 64'(rank_ok ? ans_set : ans_q);
							st_q  <= ST_SEND;
						end else begin
							bit_q <= bit_q - 5'd1;
							ra_q  <= '0;
							cnt_q <= '0;
						end
					end
				end
				ST_SEND: begin
					if (m_tready) begin
						if (idx_q == ilsm_pkg::RES_LAST) begin
							st_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + 5'd1;
							st_q  <= ST_PREP;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- design/ilsm_checker.sv -----
// ----------------------------------------------------------------------------
// ilsm_checker
// Port-level checks on the report stream of the latency monitor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "io_latency_stats_monitor_macros.svh"
module ilsm_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_tvalid,
	input wire logic       s_tready,
	input wire logic       m_tvalid,
	input wire logic       m_tready,
	input wire logic       m_tlast,
	input wire logic [4:0] m_tuser
);
	`ILSM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result beat dropped while stalled")
	`ILSM_ASSERT(a_last_idx, m_tvalid |-> (m_tlast == (m_tuser == ilsm_pkg::RES_LAST)), "tlast not on final result")
	`ILSM_ASSERT(a_no_in_during_out, m_tvalid |-> !s_tready, "input taken during a report")
	`ILSM_ASSERT_NEXT(a_report_busy, m_tvalid && m_tready && !m_tlast, !s_tready && !m_tvalid, "report left early")
endmodule

bind io_latency_stats_monitor ilsm_checker u_ilsm_checker (.*);
`default_nettype wire

// ----- dv/io_latency_stats_monitor_tb.sv -----
// ----------------------------------------------------------------------------
// io_latency_stats_monitor_tb
// Drives issue, completion and report beats with random gaps and receiver
// stalls, predicts every report beat and checks the output stream in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

class latency_scoreboard;
	typedef struct {
		logic [4:0]  idx;
		logic [63:0] value;
		logic        last;
	} report_beat_t;

	report_beat_t     pending_beats[$];
	int               errors;

	logic [47:0]      rd_cnt, wr_cnt;
	logic [63:0]      rd_sum, wr_sum;
	logic [31:0]      t_min, t_max;
	logic [15:0]      depth;
	logic [31:0]      window[$];

	function new();
		errors = 0;
		rd_cnt = '0;
		wr_cnt = '0;
		rd_sum = '0;
		wr_sum = '0;
		t_min  = '1;
		t_max  = '0;
		depth  = '0;
	endfunction

	function void push_beat(logic [4:0] k, logic [63:0] v);
		report_beat_t b;
		b.idx   = k;
		b.value = v;
		b.last  = (k == ilsm_pkg::RES_LAST);
		pending_beats.push_back(b);
	endfunction

	function logic [63:0] mean(logic [63:0] s, logic [63:0] c);
		return (c == 0) ? 64'd0 : s / c;
	endfunction

	// fold one accepted input beat into the predicted state
	function void note_input(logic [1:0] kind, logic wr, logic [31:0] t);
		longint unsigned points[11] = '{10000, 20000, 30000, 40000, 50000, 60000,
			70000, 80000, 90000, 99000, 99999};
		logic [31:0]     sorted[$];
		longint unsigned len, rank;
		if (kind == ilsm_pkg::REQ_ISSUE) begin
			depth = depth + 16'd1;
		end else if (kind == ilsm_pkg::REQ_DONE) begin
			if (wr) begin
				wr_cnt = wr_cnt + 48'd1;
				wr_sum = wr_sum + {32'd0, t};
			end else begin
				rd_cnt = rd_cnt + 48'd1;
				rd_sum = rd_sum + {32'd0, t};
			end
			if (t > t_max) t_max = t;
			if (t < t_min) t_min = t;
			depth = depth - 16'd1;
			if (window.size() >= ilsm_pkg::WIN_DEPTH) void'(window.pop_front());
			window.push_back(t);
		end else if (kind == ilsm_pkg::REQ_REPORT) begin
			sorted = window;
			sorted.sort();
			len = sorted.size();
			push_beat(ilsm_pkg::RES_RD_CNT, {16'd0, rd_cnt});
			push_beat(ilsm_pkg::RES_WR_CNT, {16'd0, wr_cnt});
			push_beat(ilsm_pkg::RES_RD_SUM, rd_sum);
			push_beat(ilsm_pkg::RES_WR_SUM, wr_sum);
			push_beat(ilsm_pkg::RES_RD_MEAN, mean(rd_sum, {16'd0, rd_cnt}));
			push_beat(ilsm_pkg::RES_WR_MEAN, mean(wr_sum, {16'd0, wr_cnt}));
			push_beat(ilsm_pkg::RES_ALL_MEAN,
				mean(rd_sum + wr_sum, {16'd0, rd_cnt} + {16'd0, wr_cnt}));
			push_beat(ilsm_pkg::RES_MIN, {32'd0, t_min});
			push_beat(ilsm_pkg::RES_MAX, {32'd0, t_max});
			push_beat(ilsm_pkg::RES_DEPTH, {48'd0, depth});
			push_beat(ilsm_pkg::RES_LEN, len);
			for (int i = 0; i < 11; i++) begin
				if (len == 0) begin
					push_beat(ilsm_pkg::RES_QTL_0 + 5'(i), 64'd0);
				end else begin
					rank = points[i] * len / 100000;
					if (rank >= len) rank = len - 1;
					push_beat(ilsm_pkg::RES_QTL_0 + 5'(i), {32'd0, sorted[rank]});
				end
			end
		end
	endfunction

	function void check_beat(logic [4:0] idx, logic [63:0] value, logic last);
		report_beat_t e;
		if (pending_beats.size() == 0) begin
			$error("unexpected report beat idx=%0d value=%0h", idx, value);
			errors++;
			return;
		end
		e = pending_beats.pop_front();
		if (idx !== e.idx) begin
			$error("result_index: expected %0d actual %0d", e.idx, idx);
			errors++;
		end
		if (value !== e.value) begin
			$error("result_value: expected %0h actual %0h", e.value, value);
			errors++;
		end
		if (last !== e.last) begin
			$error("last: expected %0b actual %0b", e.last, last);
			errors++;
		end
	endfunction
endclass

module io_latency_stats_monitor_tb;
	localparam int         STALL_LIMIT = 60000;
	localparam logic [1:0] REQ_UNUSED  = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // resp_time_ns[31:0]
	logic [2:0]  s_tuser;   // req_type[1:0], is_write[2]
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;   // result_value[63:0]
	logic [4:0]  m_tuser;   // result_index[4:0]
	logic        m_tlast;

	latency_scoreboard sb = new();
	bit                quiet;
	bit                hold_req;
	int                idle_cycles;

	io_latency_stats_monitor u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// send one beat, then maybe idle for a burst
	task automatic send_beat(logic [1:0] kind, logic wr, logic [31:0] t);
		s_tvalid <= 1'b1;
		s_tuser  <= {wr, kind};
		s_tdata  <= t;
		do @(posedge clk); while (!s_tready);
		sb.note_input(kind, wr, t);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	task automatic drain_reports();
		while (sb.pending_beats.size() != 0) @(posedge clk);
	endtask

	task automatic random_completion();
		logic [31:0] t;
		case ($urandom_range(0, 3))
			0:       t = $urandom_range(0, 1000);
			1:       t = '1 - $urandom_range(0, 3);
			default: t = $urandom();
		endcase
		send_beat(ilsm_pkg::REQ_DONE, 1'($urandom), t);
	endtask

	// receiver: random ready bursts, one long hold on request
	initial begin
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_req = 1'b0;
			end else if (!quiet && $urandom_range(0, 2) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_beat(m_tuser, m_tdata, m_tlast);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int kind_pick;
		int since_report;
		quiet    = 1'b0;
		hold_req = 1'b0;
		arst_n   = 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= '0;
		idle_cycles = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty state: zero means, min all ones, zero quantiles
		send_beat(ilsm_pkg::REQ_REPORT, 1'b0, 32'd0);
		// completion with nothing outstanding wraps the depth
		send_beat(ilsm_pkg::REQ_DONE, 1'b0, 32'd0);
		send_beat(ilsm_pkg::REQ_ISSUE, 1'b1, '1);
		send_beat(ilsm_pkg::REQ_ISSUE, 1'b0, 32'd0);
		send_beat(ilsm_pkg::REQ_DONE, 1'b1, '1);
		send_beat(REQ_UNUSED, 1'b1, '1);
		send_beat(REQ_UNUSED, 1'b0, 32'h5a5a_a5a5);
		send_beat(ilsm_pkg::REQ_REPORT, 1'b1, '1);
		send_beat(ilsm_pkg::REQ_DONE, 1'b0, '1);
		send_beat(ilsm_pkg::REQ_DONE, 1'b1, 32'd1);
		send_beat(ilsm_pkg::REQ_DONE, 1'b0, 32'h8000_0000);
		send_beat(ilsm_pkg::REQ_DONE, 1'b1, 32'h7fff_ffff);
		send_beat(ilsm_pkg::REQ_REPORT, 1'b0, 32'h1234_5678);

		// sender pause until every report beat is out
		s_tvalid <= 1'b0;
		drain_reports();
		@(posedge clk);

		since_report = 0;
		for (int n = 0; n < 260; n++) begin
			if (n == 200) quiet = 1'b1;
			kind_pick = $urandom_range(0, 99);
			if (n == 130 || (since_report >= 45 && kind_pick < 30)) begin
				// hold the receiver through one report so the input stalls behind it
				if (n == 130) hold_req = 1'b1;
				send_beat(ilsm_pkg::REQ_REPORT, 1'($urandom), $urandom());
				since_report = 0;
			end else if (kind_pick < 30) begin
				send_beat(ilsm_pkg::REQ_ISSUE, 1'($urandom), $urandom());
			end else if (kind_pick < 95) begin
				random_completion();
			end else begin
				send_beat(REQ_UNUSED, 1'($urandom), $urandom());
			end
			since_report++;
		end
		send_beat(ilsm_pkg::REQ_REPORT, 1'b0, 32'd0);
		s_tvalid <= 1'b0;

		drain_reports();
		repeat (200) @(posedge clk);
		if (sb.errors == 0 && sb.pending_beats.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule

`default_nettype wire
